### rtl/fta_pkg.sv
// shared types and constants for the frame temporal average block
package fta_pkg;

   localparam int ROW_FIELD_W = 3;
   localparam int PIX_W       = 12;
   localparam int NUM_COLS    = 8;
   localparam int MASK_LSB    = ROW_FIELD_W + NUM_COLS * PIX_W;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 112;

   localparam int DEF_RING_FRAMES = 4;
   localparam int DEF_GRID_ROWS   = 8;
   localparam int DEF_GRID_COLS   = 8;

   localparam logic [PIX_W-1:0] NEAR_THRESHOLD_RESET = 12'd127;

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic lat_we;
      logic wr_en;
      logic old_valid;
   } lane_ctl_type;

   typedef struct packed {
      logic                   last;
      logic [RSP_TDATA_W-1:0] data;
   } rsp_beat_type;

endpackage

### rtl/frame_temporal_average_threshold.sv
// top level: temporal moving average over the last frames of a range-sensor grid
//
// req channel: one beat per grid row, a row index and one distance per column.
// rows are written into the latest-frame store and give no result, except the
// last grid row: it completes the frame, which replaces the oldest frame of the
// history ring, and the block then sends GRID_ROWS result beats (row 0 first),
// each with the per-column average over the history and the occupied mask.
// rsp_tlast marks the final row of a frame. rows beyond the grid are dropped.
// csr channel: near threshold, always ready; the user writes it only while idle, the block
// does not enforce this. the first result beat passes stages s1, s2, s3 and the output
// queue, the rest follow one per cycle while rsp_tready is high. req_tready stays high after
// a non-completing row; a completing row holds it low while the row sequencer steps through
// the rows, one ring read and write per cycle while the queue has room.
// an 8-beat output queue decouples the receiver: when rsp_tready is low the
// sequencer stops issuing rows once the queue would fill, and resumes after.
// reset (synchronous) clears latest frame, running sums, ring valid bits,
// ring pointer and output queue; the threshold returns to 127. no sweep.
module frame_temporal_average_threshold import fta_pkg::*; #(
   parameter int RING_FRAMES = DEF_RING_FRAMES,
   parameter int GRID_ROWS   = DEF_GRID_ROWS,
   parameter int GRID_COLS   = DEF_GRID_COLS
) (
   input  logic                   clock,
   input  logic                   reset,
   // row_index[2:0], dist_0[14:3], dist_1 .. dist_7 in 12-bit steps up to [98:87]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // out_row[2:0], avg_0[14:3] .. avg_7[98:87], occupied_mask[106:99]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   // near_threshold
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [PIX_W-1:0]       csr_data
);

   localparam int RING_ROWS = RING_FRAMES * GRID_ROWS;
   localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int SLOT_W    = (RING_FRAMES > 1) ? $clog2(RING_FRAMES) : 1;
   localparam int RA_W      = (RING_ROWS > 1) ? $clog2(RING_ROWS) : 1;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type              state_ff;
   logic [ROW_W-1:0]       issue_row_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [PIX_W-1:0]       thr_ff;

   // row pipeline tracking
   logic                   s1_v_ff, s2_v_ff, s3_v_ff;
   logic [ROW_W-1:0]       s1_row_ff, s2_row_ff, s3_row_ff;
   logic [RA_W-1:0]        s1_addr_ff;
   logic                   old_vld_ff;
   logic [RING_ROWS-1:0]   ring_vld_ff;

   logic [ROW_FIELD_W-1:0] req_row;
   logic                   accept;
   logic                   row_ok;
   logic                   lat_we;
   logic                   frame_done;
   logic                   issue;
   logic                   issue_last;
   logic [RA_W-1:0]        rd_addr;
   logic [QCNT_W-1:0]      q_count;
   lane_ctl_type           lane_ctl;

   logic [NUM_COLS-1:0][PIX_W-1:0] lane_avg;
   logic [NUM_COLS-1:0]            lane_occ;

   assign req_row    = req_tdata[ROW_FIELD_W-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign row_ok     = (32'(req_row) < GRID_ROWS);
   assign lat_we     = accept & row_ok;
   assign frame_done = lat_we && (32'(req_row) == GRID_ROWS - 1);

   // issue a row only when the queue has room for it and all rows in flight
   assign issue      = (state_ff == ST_DRAIN) &&
                       (32'(q_count) + 32'(s1_v_ff) + 32'(s2_v_ff) + 32'(s3_v_ff)
                        < QUEUE_DEPTH);
   assign issue_last = (32'(issue_row_ff) == GRID_ROWS - 1);
   assign rd_addr    = RA_W'(32'(slot_ff) * GRID_ROWS + 32'(issue_row_ff));

   // threshold register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= NEAR_THRESHOLD_RESET;
      end else if (csr_valid & csr_ready) begin
         thr_ff <= csr_data;
      end
   end

   // row sequencer and ring pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_row_ff <= '0;
         slot_ff      <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (frame_done) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (issue) begin
                  if (issue_last) begin
                     state_ff     <= ST_IDLE;
                     issue_row_ff <= '0;
                     // the new frame now sits in this slot, next frame goes one further
                     slot_ff      <= (32'(slot_ff) == RING_FRAMES - 1) ? '0
                                                                      : slot_ff + 1'b1;
                  end else begin
                     issue_row_ff <= issue_row_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // stage valids and ring valid bits (unwritten ring rows read as zero)
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         ring_vld_ff <= '0;
      end else begin
         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         if (s1_v_ff) begin
            ring_vld_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_row_ff  <= issue_row_ff;
      s1_addr_ff <= rd_addr;
      s2_row_ff  <= s1_row_ff;
      s3_row_ff  <= s2_row_ff;
      old_vld_ff <= ring_vld_ff[rd_addr];
   end

   assign lane_ctl.lat_we    = lat_we;
   assign lane_ctl.wr_en     = s1_v_ff;
   assign lane_ctl.old_valid = old_vld_ff;

   // one lane per grid column; columns beyond the grid read as zero
   for (genvar c = 0; c < NUM_COLS; c++) begin : g_lane
      if (c < GRID_COLS) begin : g_on
         fta_lane #(
            .RING_FRAMES (RING_FRAMES),
            .GRID_ROWS   (GRID_ROWS)
         ) u_lane (
            .clock     (clock),
            .reset     (reset),
            .ctl       (lane_ctl),
            .lat_row   (ROW_W'(req_row)),
            .lat_data  (req_tdata[ROW_FIELD_W + PIX_W * c +: PIX_W]),
            .rd_row    (issue_row_ff),
            .rd_addr   (rd_addr),
            .wr_row    (s1_row_ff),
            .wr_addr   (s1_addr_ff),
            .threshold (thr_ff),
            .avg       (lane_avg[c]),
            .occupied  (lane_occ[c])
         );
      end else begin : g_off
         assign lane_avg[c] = '0;
         assign lane_occ[c] = 1'b0;
      end
   end

   fta_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .push       (s3_v_ff),
      .push_row   (ROW_FIELD_W'(s3_row_ff)),
      .push_last  (32'(s3_row_ff) == GRID_ROWS - 1),
      .avg        (lane_avg),
      .occupied   (lane_occ),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .count      (q_count)
   );

   // credit check keeps the queue from overflowing
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      s3_v_ff |-> (32'(q_count) < QUEUE_DEPTH))
      else $error("result queue full on push");

   // ring pointer moves only at the end of a frame drain
   a_slot_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> $stable(slot_ff))
      else $error("ring pointer moved outside a drain");

   // every drain starts from row zero
   a_row_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (issue_row_ff == '0))
      else $error("row sequencer not rewound while idle");

endmodule

### rtl/fta_lane.sv
// one column lane: latest row store, history ring, running sum, divide and compare
module fta_lane import fta_pkg::*; #(
   parameter int RING_FRAMES = DEF_RING_FRAMES,
   parameter int GRID_ROWS   = DEF_GRID_ROWS
) (
   input  logic                clock,
   input  logic                reset,
   input  lane_ctl_type        ctl,
   input  logic [((GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1)-1:0] lat_row,
   input  logic [PIX_W-1:0]    lat_data,
   input  logic [((GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1)-1:0] rd_row,
   input  logic [((RING_FRAMES * GRID_ROWS > 1) ?
                  $clog2(RING_FRAMES * GRID_ROWS) : 1)-1:0] rd_addr,
   input  logic [((GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1)-1:0] wr_row,
   input  logic [((RING_FRAMES * GRID_ROWS > 1) ?
                  $clog2(RING_FRAMES * GRID_ROWS) : 1)-1:0] wr_addr,
   input  logic [PIX_W-1:0]    threshold,
   output logic [PIX_W-1:0]    avg,
   output logic                occupied
);

   localparam int RING_ROWS   = RING_FRAMES * GRID_ROWS;
   localparam int SUM_W       = PIX_W + $clog2(RING_FRAMES);
   localparam int RECIP_SHIFT = SUM_W + $clog2(RING_FRAMES);
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = SUM_W + RECIP_W;
   // exact floor division by the history depth for every sum below 2**SUM_W
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(RING_FRAMES) - 64'd1) / 64'(RING_FRAMES));

   logic [PIX_W-1:0]  latest_ff [GRID_ROWS];
   logic [SUM_W-1:0]  sum_ff [GRID_ROWS];
   logic [PIX_W-1:0]  ring_mem_ff [RING_ROWS];
   logic [PIX_W-1:0]  old_ff;
   logic [PIX_W-1:0]  new_ff;
   logic [SUM_W-1:0]  acc_ff;
   logic [SUM_W-1:0]  nsum_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [SUM_W-1:0]  nsum_in;
   logic [SUM_W:0]    nsum_wide;

   // running sum: drop the slot being replaced, add the new frame pixel
   always_comb begin
      nsum_wide = {1'b0, acc_ff} + (SUM_W + 1)'(new_ff)
                  - (ctl.old_valid ? (SUM_W + 1)'(old_ff) : '0);
      nsum_in   = nsum_wide[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < GRID_ROWS; r++) begin
            latest_ff[r] <= '0;
            sum_ff[r]    <= '0;
         end
      end else begin
         if (ctl.lat_we) begin
            latest_ff[lat_row] <= lat_data;
         end
         if (ctl.wr_en) begin
            sum_ff[wr_row] <= nsum_in;
         end
      end
   end

   // history ring, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         ring_mem_ff[wr_addr] <= new_ff;
      end
      old_ff <= ring_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      new_ff  <= latest_ff[rd_row];
      acc_ff  <= sum_ff[rd_row];
      nsum_ff <= nsum_in;
      prod_ff <= PROD_W'(nsum_ff) * PROD_W'(RECIP);
   end

   assign avg      = prod_ff[RECIP_SHIFT +: PIX_W];
   assign occupied = (avg <= threshold);

endmodule

### rtl/fta_merge.sv
// merges lane results into result beats and queues them for the output
module fta_merge import fta_pkg::*; (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic [ROW_FIELD_W-1:0]             push_row,
   input  logic                               push_last,
   input  logic [NUM_COLS-1:0][PIX_W-1:0]     avg,
   input  logic [NUM_COLS-1:0]                occupied,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [RSP_TDATA_W-1:0]             rsp_tdata,
   output logic                               rsp_tlast,
   output logic [QCNT_W-1:0]                  count
);

   rsp_beat_type         queue_ff [QUEUE_DEPTH];
   rsp_beat_type         beat_in;
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QCNT_W-1:0]    count_ff;
   logic                 pop;

   always_comb begin
      beat_in.data = '0;
      beat_in.data[ROW_FIELD_W-1:0] = push_row;
      for (int c = 0; c < NUM_COLS; c++) begin
         beat_in.data[ROW_FIELD_W + PIX_W * c +: PIX_W] = avg[c];
      end
      beat_in.data[MASK_LSB +: NUM_COLS] = occupied;
      beat_in.last = push_last;
   end

   assign pop        = rsp_tvalid & rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = queue_ff[rd_ptr_ff].data;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;
   assign count      = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

### tb/sv/frame_temporal_average_threshold_tb.sv
// self-checking testbench for the frame temporal average threshold block
module frame_temporal_average_threshold_tb;
   import fta_pkg::*;

   localparam int HISTORY       = DEF_RING_FRAMES;
   localparam int GRID_ROWS     = DEF_GRID_ROWS;
   localparam int GRID_COLS     = DEF_GRID_COLS;
   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_STALL    = 120;
   localparam int REPORT_LIMIT  = 10;

   // one input row: row index in the low bits, column 0 right above it
   typedef struct packed {
      logic [NUM_COLS-1:0][PIX_W-1:0] dist_mm;
      logic [ROW_FIELD_W-1:0]         row;
   } grid_row_type;

   // one averaged row as it should leave the block
   typedef struct packed {
      logic                           last;
      logic [NUM_COLS-1:0]            mask;
      logic [NUM_COLS-1:0][PIX_W-1:0] avg;
      logic [ROW_FIELD_W-1:0]         row;
   } avg_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [PIX_W-1:0]       csr_data = '0;

   frame_temporal_average_threshold #(
      .RING_FRAMES (HISTORY),
      .GRID_ROWS   (GRID_ROWS),
      .GRID_COLS   (GRID_COLS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // predictor state: latest frame, history ring, ring pointer, threshold
   logic [PIX_W-1:0] latest_px  [GRID_ROWS][NUM_COLS];
   logic [PIX_W-1:0] history_px [HISTORY][GRID_ROWS][NUM_COLS];
   int               history_slot;
   logic [PIX_W-1:0] near_thr;

   grid_row_type rows_to_send [$];   // rows waiting for the driver
   avg_row_type  avg_rows_due [$];   // averaged rows the block still owes us
   grid_row_type row_on_bus;         // row currently offered on req
   bit        row_taken = 1'b0;   // set at the edge that accepted row_on_bus
   bit        calm = 1'b0;        // no idling on either side once set
   bit        long_stall_req = 1'b0;
   int        mismatches = 0;
   int        beats_seen = 0;

   // sender and receiver idling state
   int send_gap = 0;
   int send_quiet = 0;
   int recv_gap = 0;
   int recv_quiet = 0;

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%s", msg);
      end
   endtask

   // fold one accepted row into the predictor; a completing row yields a full frame
   task automatic absorb_row(input grid_row_type item);
      logic [PIX_W+3:0] sum;
      logic [PIX_W-1:0] mean;
      avg_row_type      res;
      if (item.row >= GRID_ROWS) begin
         return;
      end
      for (int c = 0; c < GRID_COLS; c++) begin
         latest_px[item.row][c] = item.dist_mm[c];
      end
      if (item.row != GRID_ROWS - 1) begin
         return;
      end
      // completed frame overwrites the oldest history slot
      for (int r = 0; r < GRID_ROWS; r++) begin
         for (int c = 0; c < GRID_COLS; c++) begin
            history_px[history_slot][r][c] = latest_px[r][c];
         end
      end
      history_slot = (history_slot + 1) % HISTORY;
      for (int r = 0; r < GRID_ROWS; r++) begin
         res = '0;
         res.row = r[ROW_FIELD_W-1:0];
         for (int c = 0; c < GRID_COLS; c++) begin
            sum = '0;
            for (int h = 0; h < HISTORY; h++) begin
               sum += history_px[h][r][c];
            end
            mean = PIX_W'(sum / HISTORY);
            res.avg[c] = mean;
            res.mask[c] = (mean <= near_thr);
         end
         res.last = (r == GRID_ROWS - 1);
         avg_rows_due.push_back(res);
      end
   endtask

   // compare one result beat, field by field, against the oldest expectation
   task automatic check_avg_row();
      avg_row_type want;
      avg_row_type got;
      got.row  = rsp_tdata[ROW_FIELD_W-1:0];
      got.avg  = rsp_tdata[MASK_LSB-1:ROW_FIELD_W];
      got.mask = rsp_tdata[MASK_LSB +: NUM_COLS];
      got.last = rsp_tlast;
      beats_seen++;
      if (avg_rows_due.size() == 0) begin
         report($sformatf("result beat %0d not expected: out_row %0d, tlast %0b",
                          beats_seen, got.row, got.last));
         return;
      end
      want = avg_rows_due.pop_front();
      if (got.row !== want.row) begin
         report($sformatf("beat %0d out_row: expected %0d, got %0d",
                          beats_seen, want.row, got.row));
      end
      for (int c = 0; c < NUM_COLS; c++) begin
         if (got.avg[c] !== want.avg[c]) begin
            report($sformatf("beat %0d row %0d avg_%0d: expected %0d, got %0d",
                             beats_seen, want.row, c, want.avg[c], got.avg[c]));
         end
      end
      if (got.mask !== want.mask) begin
         report($sformatf("beat %0d row %0d occupied_mask: expected %b, got %b",
                          beats_seen, want.row, want.mask, got.mask));
      end
      if (got.last !== want.last) begin
         report($sformatf("beat %0d row %0d last_row: expected %0b, got %0b",
                          beats_seen, want.row, want.last, got.last));
      end
   endtask

   // all three channels are sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            near_thr = csr_data;
         end
         if (req_tvalid && req_tready) begin
            absorb_row(row_on_bus);
            row_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            check_avg_row();
         end
      end
   end

   // row driver: holds a row until it is taken, then idles or offers the next
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || row_taken) begin
         row_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (!calm && send_quiet == 0 && $urandom_range(0, 4) == 0) begin
            // random idle burst, sometimes followed by a busy stretch
            send_gap = $urandom_range(1, 19) - 1;
            req_tvalid <= 1'b0;
            if ($urandom_range(0, 3) == 0) begin
               send_quiet = $urandom_range(20, 60);
            end
         end else if (rows_to_send.size() > 0) begin
            row_on_bus = rows_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_TDATA_W'(row_on_bus);
         end else begin
            req_tvalid <= 1'b0;
         end
         if (send_quiet > 0) begin
            send_quiet--;
         end
      end
   end

   // receiver: random stall bursts, plus one long hold-off that backs up the block
   always @(negedge clock) begin
      if (long_stall_req) begin
         long_stall_req = 1'b0;
         recv_gap = LONG_STALL;
      end
      if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else if (!calm && recv_quiet == 0 && $urandom_range(0, 4) == 0) begin
         recv_gap = $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
         if ($urandom_range(0, 3) == 0) begin
            recv_quiet = $urandom_range(20, 60);
         end
      end else begin
         rsp_tready <= 1'b1;
      end
      if (recv_quiet > 0) begin
         recv_quiet--;
      end
   end

   function automatic grid_row_type uniform_row(input int row,
                                                input logic [PIX_W-1:0] value);
      grid_row_type item;
      item.row = row[ROW_FIELD_W-1:0];
      for (int c = 0; c < NUM_COLS; c++) begin
         item.dist_mm[c] = value;
      end
      return item;
   endfunction

   // random row content; smaller ranges keep averages near typical thresholds
   function automatic grid_row_type random_row(input int row);
      grid_row_type item;
      int           span;
      span = $urandom_range(0, 3);
      item.row = row[ROW_FIELD_W-1:0];
      for (int c = 0; c < NUM_COLS; c++) begin
         case (span)
            0: begin
               item.dist_mm[c] = PIX_W'($urandom_range(0, 4095));
            end
            1: begin
               item.dist_mm[c] = PIX_W'($urandom_range(0, 255));
            end
            2: begin
               item.dist_mm[c] = PIX_W'($urandom_range(0, 1023));
            end
            default: begin
               item.dist_mm[c] = $urandom_range(0, 1) ? '1 : '0;
            end
         endcase
      end
      return item;
   endfunction

   // mostly complete frames in row order, some partial runs and stray rows
   task automatic queue_random_traffic(input int rows);
      int n;
      int kind;
      int len;
      n = 0;
      while (n < rows) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            for (int r = 0; r < GRID_ROWS; r++) begin
               rows_to_send.push_back(random_row(r));
            end
            n += GRID_ROWS;
         end else if (kind < 9) begin
            len = $urandom_range(1, 6);
            repeat (len) rows_to_send.push_back(random_row($urandom_range(0, 7)));
            n += len;
         end else begin
            rows_to_send.push_back(random_row(GRID_ROWS - 1));
            n++;
         end
      end
   endtask

   // wait until every queued row is taken and every owed result has come back
   task automatic wait_until_drained();
      bit busy;
      busy = 1'b1;
      while (busy) begin
         @(posedge clock);
         #1;
         busy = rows_to_send.size() > 0 || req_tvalid || avg_rows_due.size() > 0;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // threshold write, only issued while the block is idle
   task automatic write_threshold(input logic [PIX_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      grid_row_type item;
      for (int r = 0; r < GRID_ROWS; r++) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            latest_px[r][c] = '0;
            for (int h = 0; h < HISTORY; h++) begin
               history_px[h][r][c] = '0;
            end
         end
      end
      history_slot = 0;
      near_thr = NEAR_THRESHOLD_RESET;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset threshold: all-max frame against a zero ring
      for (int r = 0; r < GRID_ROWS; r++) begin
         rows_to_send.push_back(uniform_row(r, '1));
      end
      // lone last row: rows 0..6 must keep their earlier values
      rows_to_send.push_back(uniform_row(GRID_ROWS - 1, '0));
      // alternating bit patterns on every row and column
      for (int r = 0; r < GRID_ROWS; r++) begin
         item = uniform_row(r, (r % 2) ? 12'h555 : 12'hAAA);
         for (int c = 1; c < NUM_COLS; c += 2) begin
            item.dist_mm[c] = ~item.dist_mm[c];
         end
         rows_to_send.push_back(item);
      end
      // fill the ring, then wrap the pointer back to the first slot
      rows_to_send.push_back(uniform_row(GRID_ROWS - 1, '0));
      rows_to_send.push_back(uniform_row(GRID_ROWS - 1, '1));
      rows_to_send.push_back(uniform_row(2, 12'd1));
      rows_to_send.push_back(uniform_row(GRID_ROWS - 1, 12'd127));
      wait_until_drained();

      // every average counts as occupied
      write_threshold('1);
      queue_random_traffic(40);
      wait_until_drained();

      // only exact zero averages count
      write_threshold('0);
      queue_random_traffic(40);
      wait_until_drained();

      // receiver holds off while four frames are offered, so the block backs up
      write_threshold(PIX_W'($urandom_range(64, 512)));
      long_stall_req = 1'b1;
      for (int f = 0; f < 4; f++) begin
         for (int r = 0; r < GRID_ROWS; r++) begin
            rows_to_send.push_back(random_row(r));
         end
      end
      wait_until_drained();

      write_threshold(PIX_W'($urandom_range(0, 4095)));
      queue_random_traffic(30);
      wait_until_drained();

      // last stretch runs at full rate on both sides
      write_threshold(12'd200);
      calm = 1'b1;
      queue_random_traffic(40);
      wait_until_drained();

      if (mismatches == 0 && avg_rows_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
